// ===== rtl/cascaded_biquad_iir_decimator_macros.svh =====
// Assertion macros for the checker file of the biquad decimator.
// Each macro expands to one labeled concurrent assertion on a clock and a reset.
`ifndef CASCADED_BIQUAD_IIR_DECIMATOR_MACROS_SVH
`define CASCADED_BIQUAD_IIR_DECIMATOR_MACROS_SVH

// Overlapping implication, checked on every rising edge outside reset.
`define CBQ_ASSERT_IMP(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the following cycle, checked outside reset.
`define CBQ_ASSERT_NXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cbq_pkg.sv =====
// Package of the cascaded biquad decimator: sizes, operation codes, types and
// the fixed-point rounding helpers. Depends on nothing.
`default_nettype none

package cbq_pkg;

  localparam int MAX_SECTIONS = 8;
  localparam int SAMPLE_BITS  = 24;
  localparam int COEF_BITS    = 24;
  localparam int DELAY_BITS   = 32;
  localparam int SLOTS        = 5;
  localparam int PROD_BITS    = COEF_BITS + DELAY_BITS;
  localparam int ACC_BITS     = 64;

  localparam int SEC_W      = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int DLY_AW     = SEC_W + 1;
  localparam int DLY_DEPTH  = 2 * MAX_SECTIONS;
  localparam int COEF_DEPTH = SLOTS * MAX_SECTIONS;
  localparam int COEF_AW    = $clog2(COEF_DEPTH);
  localparam int X_SHIFT    = 46 - SAMPLE_BITS;
  localparam int CFG_AW     = 3;
  localparam int DEC_MAX    = 16;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_COEF   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_B1 = 3'd1;
  localparam logic [2:0] SLOT_B2 = 3'd2;
  localparam logic [2:0] SLOT_A1 = 3'd3;
  localparam logic [2:0] SLOT_A2 = 3'd4;

  localparam logic signed [ACC_BITS-1:0] RND_Q45 = 64'sd1 <<< 21;
  localparam logic signed [ACC_BITS-1:0] W_MAX   = 64'sd2147483647;
  localparam logic signed [ACC_BITS-1:0] W_MIN   = -64'sd2147483648;

  localparam int OUT_RSH = (SAMPLE_BITS < 24) ? 24 - SAMPLE_BITS : 0;
  localparam int OUT_LSH = (SAMPLE_BITS > 24) ? SAMPLE_BITS - 24 : 0;
  localparam logic signed [ACC_BITS-1:0] OUT_RND = (64'sd1 <<< OUT_RSH) >>> 1;
  localparam logic signed [ACC_BITS-1:0] OUT_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [ACC_BITS-1:0] OUT_MIN = -OUT_MAX - 64'sd1;

  typedef struct packed {
    logic [1:0]                    operation;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic [2:0]                    coef_section;
    logic [2:0]                    coef_slot;
    logic signed [COEF_BITS-1:0]   coef_value;
  } item_t;

  typedef struct packed {
    logic [4:0] decimation_factor;
    logic [3:0] active_sections;
  } cfg_t;

  typedef struct packed {
    logic                          valid;
    logic signed [SAMPLE_BITS-1:0] sample;
  } res_t;

  function automatic logic [COEF_AW-1:0] coef_addr(input int unsigned sec,
                                                   input logic [2:0] slot);
    return COEF_AW'(sec * SLOTS + int'(slot));
  endfunction

  // Q.45 accumulator to Q.23 delay word, round half up, then saturate.
  function automatic logic signed [DELAY_BITS-1:0] round_q45(
      input logic signed [ACC_BITS-1:0] acc);
    logic signed [ACC_BITS-1:0] t;
    t = (acc + RND_Q45) >>> 22;
    if (t > W_MAX) begin
      t = W_MAX;
    end else if (t < W_MIN) begin
      t = W_MIN;
    end
    return DELAY_BITS'(t);
  endfunction

  // Q9.23 section output to the output sample format, saturated.
  function automatic logic signed [SAMPLE_BITS-1:0] to_out(
      input logic signed [DELAY_BITS-1:0] y);
    logic signed [ACC_BITS-1:0] t;
    t = ((ACC_BITS'(y) + OUT_RND) >>> OUT_RSH) <<< OUT_LSH;
    if (t > OUT_MAX) begin
      t = OUT_MAX;
    end else if (t < OUT_MIN) begin
      t = OUT_MIN;
    end
    return SAMPLE_BITS'(t);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cbq_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
// Depends on cbq_pkg for the payload widths.
`default_nettype none

interface cbq_item_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             operation;
  logic signed [cbq_pkg::SAMPLE_BITS-1:0] in_sample;
  logic [2:0]                             coef_section;
  logic [2:0]                             coef_slot;
  logic signed [cbq_pkg::COEF_BITS-1:0]   coef_value;

  modport source (output valid, operation, in_sample, coef_section, coef_slot, coef_value,
                  input ready);
  modport sink (input valid, operation, in_sample, coef_section, coef_slot, coef_value,
                output ready);
endinterface

interface cbq_result_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [cbq_pkg::SAMPLE_BITS-1:0] out_sample;

  modport source (output valid, out_sample, input ready);
  modport sink (input valid, out_sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/cbq_core.sv =====
// Filter engine: delay and coefficient memories, one shared multiplier and the
// section sequencer with the decimation phase. Depends on cbq_pkg.
`default_nettype none

module cbq_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire cbq_pkg::item_t item,
  input  wire cbq_pkg::cfg_t  cfg,
  input  wire logic          out_free,
  output logic               idle,
  output cbq_pkg::res_t      res
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [1:0] ST_OUT    = 2'd3;

  localparam logic [2:0] K_FETCH  = 3'd0;
  localparam logic [2:0] K_MUL_A1 = 3'd1;
  localparam logic [2:0] K_MUL_A2 = 3'd2;
  localparam logic [2:0] K_MUL_B1 = 3'd3;
  localparam logic [2:0] K_MUL_B2 = 3'd4;
  localparam logic [2:0] K_MUL_B0 = 3'd5;
  localparam logic [2:0] K_SUM    = 3'd6;

  logic [1:0]                               state;
  logic [2:0]                               step;
  logic [cbq_pkg::SEC_W-1:0]                sec;
  logic [3:0]                               phase;

  logic signed [cbq_pkg::SAMPLE_BITS-1:0]   x_in;
  logic signed [cbq_pkg::DELAY_BITS-1:0]    w1, w2, w, y;
  logic signed [cbq_pkg::PROD_BITS-1:0]     prod, mul_p;
  logic signed [cbq_pkg::ACC_BITS-1:0]      acc, accy, x45;
  logic signed [cbq_pkg::DELAY_BITS-1:0]    mul_b;

  logic signed [cbq_pkg::DELAY_BITS-1:0]    dmem [cbq_pkg::DLY_DEPTH];
  logic [cbq_pkg::DLY_DEPTH-1:0]            dvalid;
  logic signed [cbq_pkg::COEF_BITS-1:0]     cmem [cbq_pkg::COEF_DEPTH];

  logic signed [cbq_pkg::DELAY_BITS-1:0]    dq_raw, dq, d_wdata;
  logic                                     dv, d_we, c_we, clear;
  logic signed [cbq_pkg::COEF_BITS-1:0]     cq;
  logic [cbq_pkg::DLY_AW-1:0]               d_raddr, d_waddr;
  logic [cbq_pkg::COEF_AW-1:0]              c_raddr, c_waddr;
  logic [2:0]                               rd_slot;

  logic [4:0]                               nsec_c, dec_c, phase_inc;
  logic [cbq_pkg::SEC_W-1:0]                last_sec;
  logic                                     emit_due;

  always_comb begin
    nsec_c = {1'b0, cfg.active_sections};
    if (nsec_c == 5'd0) begin
      nsec_c = 5'd1;
    end else if (nsec_c > 5'(cbq_pkg::MAX_SECTIONS)) begin
      nsec_c = 5'(cbq_pkg::MAX_SECTIONS);
    end
    last_sec = cbq_pkg::SEC_W'(nsec_c - 5'd1);

    dec_c = cfg.decimation_factor;
    if (dec_c == 5'd0) begin
      dec_c = 5'd1;
    end else if (dec_c > 5'(cbq_pkg::DEC_MAX)) begin
      dec_c = 5'(cbq_pkg::DEC_MAX);
    end
    phase_inc = {1'b0, phase} + 5'd1;
    emit_due  = !(phase_inc < dec_c);
  end

  assign idle = (state == ST_IDLE);
  assign res.valid  = (state == ST_OUT) && emit_due && out_free;
  assign res.sample = cbq_pkg::to_out(y);

  // Item decode for the coefficient-write and clear operations.
  assign clear   = start && (item.operation == cbq_pkg::OP_CLEAR);
  assign c_we    = start && (item.operation == cbq_pkg::OP_COEF) &&
                   (item.coef_slot <= cbq_pkg::SLOT_A2) &&
                   (int'(item.coef_section) < cbq_pkg::MAX_SECTIONS);
  assign c_waddr = cbq_pkg::coef_addr(int'(item.coef_section), item.coef_slot);

  // Read schedule: each step fetches the coefficient used by the next step.
  always_comb begin
    case (step)
      K_FETCH:  rd_slot = cbq_pkg::SLOT_A1;
      K_MUL_A1: rd_slot = cbq_pkg::SLOT_A2;
      K_MUL_A2: rd_slot = cbq_pkg::SLOT_B1;
      K_MUL_B1: rd_slot = cbq_pkg::SLOT_B2;
      default:  rd_slot = cbq_pkg::SLOT_B0;
    endcase
  end

  assign c_raddr = cbq_pkg::coef_addr(int'(sec), rd_slot);
  assign d_raddr = {sec, (step == K_MUL_A1)};

  // The old w1 moves to the w2 slot, and the new w lands in the w1 slot.
  assign d_we    = (state == ST_RUN) && ((step == K_MUL_A2) || (step == K_MUL_B0));
  assign d_waddr = {sec, (step == K_MUL_A2)};
  assign d_wdata = (step == K_MUL_A2) ? w1 : w;

  assign dq = dv ? dq_raw : '0;

  always_comb begin
    case (step)
      K_MUL_A1, K_MUL_A2: mul_b = dq;
      K_MUL_B1:           mul_b = w1;
      K_MUL_B2:           mul_b = w2;
      default:            mul_b = w;
    endcase
  end

  assign mul_p = cbq_pkg::PROD_BITS'(cq) * cbq_pkg::PROD_BITS'(mul_b);
  assign x45   = (sec == '0) ? (cbq_pkg::ACC_BITS'(x_in) <<< cbq_pkg::X_SHIFT)
                             : (cbq_pkg::ACC_BITS'(y) <<< 22);

  always_ff @(posedge clk) begin
    dq_raw <= dmem[d_raddr];
    dv     <= dvalid[d_raddr];
    cq     <= cmem[c_raddr];
    if (d_we) begin
      dmem[d_waddr] <= d_wdata;
    end
    if (c_we) begin
      cmem[c_waddr] <= item.coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvalid <= '0;
    end else if (clear) begin
      dvalid <= '0;
    end else if (d_we) begin
      dvalid[d_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start && (item.operation == cbq_pkg::OP_SAMPLE)) begin
      x_in <= item.in_sample;
    end
    if (state == ST_RUN) begin
      prod <= mul_p;
      case (step)
        K_FETCH: begin
          if (sec != '0) begin
            y <= cbq_pkg::round_q45(accy);
          end
        end
        K_MUL_A1: begin
          w1 <= dq;
        end
        K_MUL_A2: begin
          w2  <= dq;
          acc <= x45 - cbq_pkg::ACC_BITS'(prod);
        end
        K_MUL_B1: begin
          acc <= acc - cbq_pkg::ACC_BITS'(prod);
        end
        K_MUL_B2: begin
          w    <= cbq_pkg::round_q45(acc);
          accy <= cbq_pkg::ACC_BITS'(prod);
        end
        K_MUL_B0, K_SUM: begin
          accy <= accy + cbq_pkg::ACC_BITS'(prod);
        end
        default: begin
        end
      endcase
    end else if (state == ST_FINISH) begin
      y <= cbq_pkg::round_q45(accy);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= K_FETCH;
      sec   <= '0;
      phase <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (clear) begin
            phase <= '0;
          end
          if (start && (item.operation == cbq_pkg::OP_SAMPLE)) begin
            state <= ST_RUN;
            step  <= K_FETCH;
            sec   <= '0;
          end
        end
        ST_RUN: begin
          if (step == K_SUM) begin
            step <= K_FETCH;
            if (sec == last_sec) begin
              state <= ST_FINISH;
            end else begin
              sec <= sec + 1'b1;
            end
          end else begin
            step <= step + 3'd1;
          end
        end
        ST_FINISH: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!emit_due) begin
            phase <= phase_inc[3:0];
            state <= ST_IDLE;
          end else if (out_free) begin
            phase <= '0;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cascaded_biquad_iir_decimator.sv =====
// A sample runs the steps of every active section, then the finish and output states; the
// input is not ready until the core is idle again. The shared multiplier does five products
// per section. Coefficient writes, clears and unused operations leave the core idle.
// Reset returns the control, the phase and the registers to their defaults and marks
// all delays as zero; the coefficient memory keeps no reset value.
`default_nettype none

module cascaded_biquad_iir_decimator (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [cbq_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  cbq_item_if.sink                         item,
  cbq_result_if.source                     result
);

  localparam logic REG_DEC = 1'b0;
  localparam logic REG_SEC = 1'b1;

  logic [4:0]     decimation_factor;
  logic [3:0]     active_sections;
  logic           cfg_wr, core_idle, start, out_free;
  cbq_pkg::item_t item_data;
  cbq_pkg::cfg_t  cfg;
  cbq_pkg::res_t  res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[cbq_pkg::CFG_AW-1] == REG_SEC) ? 32'(active_sections)
                                                        : 32'(decimation_factor);

  always_ff @(posedge clk) begin
    if (rst) begin
      decimation_factor <= 5'd4;
      active_sections   <= 4'd8;
    end else if (cfg_wr) begin
      if (paddr[cbq_pkg::CFG_AW-1] == REG_DEC) begin
        decimation_factor <= pwdata[4:0];
      end else begin
        active_sections <= pwdata[3:0];
      end
    end
  end

  assign cfg.decimation_factor = decimation_factor;
  assign cfg.active_sections   = active_sections;

  assign item_data.operation    = item.operation;
  assign item_data.in_sample    = item.in_sample;
  assign item_data.coef_section = item.coef_section;
  assign item_data.coef_slot    = item.coef_slot;
  assign item_data.coef_value   = item.coef_value;

  assign item.ready = core_idle;
  assign start      = item.valid && core_idle;
  assign out_free   = !result.valid || result.ready;

  cbq_core u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item_data),
    .cfg      (cfg),
    .out_free (out_free),
    .idle     (core_idle),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (res.valid) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      result.out_sample <= res.sample;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cbq_checker.sv =====
// Port-level checks of the biquad decimator, attached by the bind at the end.
// Depends on cbq_pkg and the assertion macros header.
`default_nettype none
`include "cascaded_biquad_iir_decimator_macros.svh"

module cbq_checker (
  input wire logic                                   clk,
  input wire logic                                   rst,
  input wire logic                                   item_valid,
  input wire logic                                   item_ready,
  input wire logic [1:0]                             item_operation,
  input wire logic                                   result_valid,
  input wire logic                                   result_ready,
  input wire logic signed [cbq_pkg::SAMPLE_BITS-1:0] result_out_sample
);

  `CBQ_ASSERT_NXT(a_sample_busy, clk, rst, item_valid && item_ready && item_operation == cbq_pkg::OP_SAMPLE, !item_ready, "sample transaction did not start the filter pass")
  `CBQ_ASSERT_NXT(a_short_ops, clk, rst, item_valid && item_ready && item_operation != cbq_pkg::OP_SAMPLE, item_ready, "non-sample transaction blocked the input")
  `CBQ_ASSERT_IMP(a_result_origin, clk, rst, $rose(result_valid), item_ready && $past(!item_ready), "result appeared without a finished filter pass")
  `CBQ_ASSERT_NXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result_out_sample), "stalled result changed")

endmodule

bind cascaded_biquad_iir_decimator cbq_checker u_cbq_checker (
  .clk               (clk),
  .rst               (rst),
  .item_valid        (item.valid),
  .item_ready        (item.ready),
  .item_operation    (item.operation),
  .result_valid      (result.valid),
  .result_ready      (result.ready),
  .result_out_sample (result.out_sample)
);

`default_nettype wire

// ===== bench/tb_cascaded_biquad_iir_decimator.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the cascaded biquad decimator: directed and random traffic on the
// item channel, APB register changes between phases, and a bit-exact fixed-point filter
// predictor. Depends on cbq_pkg, the channel interfaces and the RTL top.

module tb_cascaded_biquad_iir_decimator;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam logic [2:0] REG_DECIMATION = 3'd0;
  localparam logic [2:0] REG_SECTIONS   = 3'd4;
  localparam logic [2:0] FIRST_BAD_SLOT = 3'd5;
  localparam int         SETTLE_CYCLES  = 7 * cbq_pkg::MAX_SECTIONS + 20;
  localparam int         RANDOM_PHASES  = 14;
  localparam int         PHASE_ITEMS    = 30;

  localparam longint Q23_MAX = 64'sd2147483647;
  localparam longint Q23_MIN = -Q23_MAX - 64'sd1;
  localparam longint OUT_MAX = 64'sd8388607;
  localparam longint OUT_MIN = -OUT_MAX - 64'sd1;
  localparam logic signed [23:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SAMPLE_MIN = 24'sh800000;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cbq_item_if   item_ch ();
  cbq_result_if res_ch ();

  cascaded_biquad_iir_decimator dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (item_ch),
    .result  (res_ch)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  cbq_pkg::item_t          pending_items[$];
  logic signed [23:0]      expected_samples[$];
  cbq_pkg::item_t          next_item;

  logic [4:0]              dec_reg;
  logic [3:0]              sec_reg;
  int                      w_state [2 * cbq_pkg::MAX_SECTIONS];
  logic signed [23:0]      coef_mem [cbq_pkg::MAX_SECTIONS][cbq_pkg::SLOTS];
  int unsigned             group_phase;

  int fail_count;
  int n_samples;
  int n_coef;
  int n_clear;
  int n_unused;
  int n_results;
  int n_configs;

  int unsigned burst_left;
  int unsigned gap_left;
  logic [15:0] stall_pattern;
  logic [3:0]  pat_idx;

  function automatic int q45_to_q23(input longint acc);
    longint t;
    t = (acc + (64'sd1 <<< 21)) >>> 22;
    if (t > Q23_MAX) t = Q23_MAX;
    else if (t < Q23_MIN) t = Q23_MIN;
    return int'(t);
  endfunction

  // Runs one sample through the active sections; returns 1 when a decimated output is due.
  function automatic bit filter_sample(input logic signed [23:0] x,
                                       output logic signed [23:0] y_out);
    int unsigned dec;
    int unsigned nsec;
    int unsigned s;
    longint      xin;
    longint      w1;
    longint      w2;
    longint      acc;
    int          w;
    int          y;
    dec = dec_reg;
    if (dec < 1) dec = 1;
    if (dec > cbq_pkg::DEC_MAX) dec = cbq_pkg::DEC_MAX;
    nsec = sec_reg;
    if (nsec < 1) nsec = 1;
    if (nsec > cbq_pkg::MAX_SECTIONS) nsec = cbq_pkg::MAX_SECTIONS;
    xin = longint'(x) <<< 22;
    y = 0;
    y_out = '0;
    for (s = 0; s < nsec; s++) begin
      w1 = w_state[2 * s];
      w2 = w_state[2 * s + 1];
      acc = xin - longint'(coef_mem[s][cbq_pkg::SLOT_A1]) * w1
                - longint'(coef_mem[s][cbq_pkg::SLOT_A2]) * w2;
      w = q45_to_q23(acc);
      acc = longint'(coef_mem[s][cbq_pkg::SLOT_B0]) * longint'(w)
          + longint'(coef_mem[s][cbq_pkg::SLOT_B1]) * w1
          + longint'(coef_mem[s][cbq_pkg::SLOT_B2]) * w2;
      y = q45_to_q23(acc);
      w_state[2 * s + 1] = int'(w1);
      w_state[2 * s] = w;
      xin = longint'(y) <<< 22;
    end
    if (group_phase + 1 < dec) begin
      group_phase = (group_phase + 1) & 4'hF;
      return 1'b0;
    end
    group_phase = 0;
    if (longint'(y) > OUT_MAX) y_out = SAMPLE_MAX;
    else if (longint'(y) < OUT_MIN) y_out = SAMPLE_MIN;
    else y_out = 24'(y);
    return 1'b1;
  endfunction

  function automatic cbq_pkg::item_t blank_item(input logic [1:0] op);
    cbq_pkg::item_t it;
    it.operation    = op;
    it.in_sample    = 24'($urandom);
    it.coef_section = 3'($urandom);
    it.coef_slot    = 3'($urandom);
    it.coef_value   = 24'($urandom);
    return it;
  endfunction

  function automatic logic signed [23:0] coef_value_for(input logic [2:0] slot, input bit wild);
    if (wild) return 24'($urandom);
    if (slot == cbq_pkg::SLOT_A2) return 24'($urandom_range(0, 3145728));
    if (slot == cbq_pkg::SLOT_A1) return 24'(int'($urandom_range(0, 5033164)) - 2516582);
    return 24'(int'($urandom_range(0, 2097152)) - 1048576);
  endfunction

  function automatic logic signed [23:0] random_sample();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k == 0) return SAMPLE_MAX;
    if (k == 1) return SAMPLE_MIN;
    if (k < 4) return 24'(int'($urandom_range(0, 4000)) - 2000);
    return 24'($urandom);
  endfunction

  task automatic push_sample(input logic signed [23:0] x);
    cbq_pkg::item_t it;
    it = blank_item(cbq_pkg::OP_SAMPLE);
    it.in_sample = x;
    pending_items.push_back(it);
  endtask

  task automatic push_coef(input logic [2:0] sec, input logic [2:0] slot,
                           input logic signed [23:0] val);
    cbq_pkg::item_t it;
    it = blank_item(cbq_pkg::OP_COEF);
    it.coef_section = sec;
    it.coef_slot = slot;
    it.coef_value = val;
    pending_items.push_back(it);
  endtask

  task automatic load_all_coefs(input bit wild);
    int s;
    int k;
    for (s = 0; s < cbq_pkg::MAX_SECTIONS; s++) begin
      for (k = 0; k < cbq_pkg::SLOTS; k++) begin
        push_coef(3'(s), 3'(k), coef_value_for(3'(k), wild));
      end
    end
  endtask

  task automatic push_random_item(input bit wild);
    int unsigned r;
    logic [2:0]  slot;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      push_sample(random_sample());
    end else if (r < 90) begin
      slot = 3'($urandom_range(0, cbq_pkg::SLOTS - 1));
      push_coef(3'($urandom), slot, coef_value_for(slot, wild));
    end else if (r < 93) begin
      push_coef(3'($urandom), 3'($urandom_range(int'(FIRST_BAD_SLOT), 7)), 24'($urandom));
    end else if (r < 97) begin
      pending_items.push_back(blank_item(cbq_pkg::OP_CLEAR));
    end else begin
      pending_items.push_back(blank_item(OP_UNUSED));
    end
  endtask

  // Upper data bits carry noise; only the register's own bits matter.
  task automatic write_reg(input logic [2:0] addr, input logic [4:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= ($urandom & 32'hFFFF_FFE0) | 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    n_configs++;
  endtask

  task automatic drain_and_settle();
    while (pending_items.size() != 0 || item_ch.valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps, sometimes none.
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!item_ch.valid || item_ch.ready) begin
      if (gap_left != 0) begin
        item_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() != 0) begin
        next_item = pending_items.pop_front();
        item_ch.valid        <= 1'b1;
        item_ch.operation    <= next_item.operation;
        item_ch.in_sample    <= next_item.in_sample;
        item_ch.coef_section <= next_item.coef_section;
        item_ch.coef_slot    <= next_item.coef_slot;
        item_ch.coef_value   <= next_item.coef_value;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: ready follows the bits of a 16-bit stall pattern in turn, redrawn at every wrap.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      pat_idx <= '0;
      stall_pattern <= 16'hFFFF;
    end else begin
      res_ch.ready <= stall_pattern[pat_idx];
      pat_idx <= pat_idx + 4'd1;
      if (pat_idx == 4'hF) begin
        case ($urandom_range(0, 2))
          0: stall_pattern <= 16'hFFFF;
          1: stall_pattern <= 16'($urandom);
          default: stall_pattern <= 16'($urandom) | 16'($urandom);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    logic signed [23:0] y;
    logic signed [23:0] want;
    if (rst) begin
      dec_reg = 5'd4;
      sec_reg = 4'd8;
      group_phase = 0;
      foreach (w_state[i]) w_state[i] = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          REG_DECIMATION: dec_reg = pwdata[4:0];
          REG_SECTIONS:   sec_reg = pwdata[3:0];
          default: ;
        endcase
      end
      if (item_ch.valid && item_ch.ready) begin
        case (item_ch.operation)
          cbq_pkg::OP_SAMPLE: begin
            n_samples++;
            if (filter_sample(item_ch.in_sample, y)) expected_samples.push_back(y);
          end
          cbq_pkg::OP_COEF: begin
            n_coef++;
            if (item_ch.coef_slot <= cbq_pkg::SLOT_A2 &&
                int'(item_ch.coef_section) < cbq_pkg::MAX_SECTIONS)
              coef_mem[item_ch.coef_section][item_ch.coef_slot] = item_ch.coef_value;
          end
          cbq_pkg::OP_CLEAR: begin
            n_clear++;
            group_phase = 0;
            foreach (w_state[i]) w_state[i] = 0;
          end
          default: n_unused++;
        endcase
      end
      if (res_ch.valid && res_ch.ready) begin
        n_results++;
        if (expected_samples.size() == 0) begin
          $error("out_sample: no output expected, actual %0d", res_ch.out_sample);
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          if (res_ch.out_sample !== want) begin
            $error("out_sample mismatch: expected %0d, actual %0d", want, res_ch.out_sample);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    int  ph;
    int  k;
    bit  wild;
    bit  wild_prev;
    logic [4:0] dec_val;
    logic [3:0] sec_val;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fail_count = 0;
    n_samples = 0;
    n_coef = 0;
    n_clear = 0;
    n_unused = 0;
    n_results = 0;
    n_configs = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part, starting from the reset register values.
    load_all_coefs(1'b0);
    for (k = 0; k < 3; k++) push_coef(3'd0, 3'(int'(FIRST_BAD_SLOT) + k), 24'($urandom));
    pending_items.push_back(blank_item(OP_UNUSED));
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    push_sample(24'sd0);
    push_sample(-24'sd1);
    push_sample(24'sd1);
    for (k = 0; k < 3; k++) push_sample(SAMPLE_MAX);
    pending_items.push_back(blank_item(cbq_pkg::OP_CLEAR));
    for (k = 0; k < 4; k++) push_sample(SAMPLE_MIN);
    drain_and_settle();

    write_reg(REG_DECIMATION, 5'd0);
    write_reg(REG_SECTIONS, 5'd0);
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    drain_and_settle();

    // The factor drops below the phase already reached in the current group.
    write_reg(REG_DECIMATION, 5'd8);
    write_reg(REG_SECTIONS, 5'd3);
    for (k = 0; k < 5; k++) push_sample(random_sample());
    drain_and_settle();
    write_reg(REG_DECIMATION, 5'd3);
    push_sample(random_sample());
    push_sample(random_sample());
    drain_and_settle();

    wild_prev = 1'b0;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin dec_val = 5'd16; sec_val = 4'd8; end
        1: begin dec_val = 5'd1; sec_val = 4'd1; end
        2: begin dec_val = 5'd31; sec_val = 4'd15; end
        default: begin
          k = $urandom_range(0, 9);
          if (k == 0) dec_val = 5'd0;
          else if (k == 1) dec_val = 5'($urandom_range(17, 31));
          else dec_val = 5'($urandom_range(1, 16));
          sec_val = 4'($urandom);
        end
      endcase
      wild = ($urandom_range(0, 4) == 0);
      write_reg(REG_DECIMATION, dec_val);
      write_reg(REG_SECTIONS, 5'(sec_val));
      if (wild != wild_prev) load_all_coefs(wild);
      wild_prev = wild;
      for (k = 0; k < PHASE_ITEMS; k++) push_random_item(wild);
      drain_and_settle();
    end

    $display("Covered %0d samples, %0d coefficient writes, %0d clears, %0d unused operations",
             n_samples, n_coef, n_clear, n_unused);
    $display("across %0d register writes; %0d output transactions checked, %0d failures.",
             n_configs, n_results, fail_count);
    if (fail_count == 0 && expected_samples.size() == 0) begin
      $display("PASS cascaded_biquad_iir_decimator");
    end else begin
      $display("FAIL cascaded_biquad_iir_decimator");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("FAIL cascaded_biquad_iir_decimator");
    $finish;
  end

endmodule

// ===== cascaded_biquad_iir_decimator.f =====
+incdir+rtl
rtl/cbq_pkg.sv
rtl/cbq_if.sv
rtl/cbq_core.sv
rtl/cascaded_biquad_iir_decimator.sv
rtl/cbq_checker.sv
bench/tb_cascaded_biquad_iir_decimator.sv
